// File: hw/rtl/rmt_pkg.sv
// rmt_pkg: payload structs and fixed widths for the running median tracker
// no dependencies; imported by rmt_cell, running_median_tracker and the testbench
`default_nettype none

package rmt_pkg;

  localparam int DATA_W = 32;
  localparam int HELD_W = 7;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_item;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] median;
    logic [HELD_W-1:0]        held_count;
    logic                     dropped;
  } out_t;

  // insertion broadcast from the control to every cell
  typedef struct packed {
    logic                     en;
    logic signed [DATA_W-1:0] sample;
  } ins_t;

endpackage

`default_nettype wire

// File: hw/rtl/rmt_cell.sv
// rmt_cell: one slot of the sorted chain, compare-and-shift insertion and
// median tap; depends on rmt_pkg
`default_nettype none

module rmt_cell
  import rmt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire                            clk,
  input  wire ins_t                      ins,
  input  wire logic [CNT_W-1:0]          fill,
  input  wire logic                      left_gt,
  input  wire logic signed [DATA_W-1:0]  left_val,
  input  wire logic [CNT_W-1:0]          lo_idx,
  input  wire logic [CNT_W-1:0]          hi_idx,
  output logic                           gt,
  output logic signed [DATA_W-1:0]       val,
  output logic [DATA_W-1:0]              lo_tap,
  output logic [DATA_W-1:0]              hi_tap
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;
  logic                     occ;
  logic                     wr;

  assign occ = MyIdx < fill;
  assign gt  = occ && (val_r > ins.sample);
  assign wr  = ins.en && (gt || (MyIdx == fill));
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (wr) begin
      val_nxt = left_gt ? left_val : ins.sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign lo_tap = (MyIdx == lo_idx) ? val_r : '0;
  assign hi_tap = (MyIdx == hi_idx) ? val_r : '0;

endmodule

`default_nettype wire

// File: hw/rtl/running_median_tracker.sv
// running_median_tracker: top level, control and a row of rmt_cell slots
// depends on rmt_pkg and rmt_cell
//
//   channel | direction | payload | handshake
//   in_     | input     | in_t    | in_valid / in_stall
//   out_    | output    | out_t   | out_valid / out_stall
//
// each transfer steps through: insert into the cell row, tap the two
// middle cells into lo_r/hi_r, then add and halve into the output register
// a new input is taken once the previous result is in the output register,
// even while that result still waits under out_stall
// rst_n (synchronous) empties the store; cell contents are not cleared
`default_nettype none

module running_median_tracker
  import rmt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire in_t   in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_t       out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_SUM
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [CNT_W-1:0]         n_r;
  logic [CNT_W-1:0]         n_nxt;
  logic [CNT_W-1:0]         lo_idx_r;
  logic [CNT_W-1:0]         hi_idx_r;
  logic                     drop_r;
  logic signed [DATA_W-1:0] lo_r;
  logic signed [DATA_W-1:0] hi_r;
  logic                     out_valid_r;
  out_t                     out_r;

  logic                     accept;
  logic                     drop;
  ins_t                     ins;
  logic [CNT_W-1:0]         hi_idx_nxt;
  logic [CNT_W-1:0]         lo_idx_nxt;

  logic                     gt   [CAPACITY];
  logic signed [DATA_W-1:0] val  [CAPACITY];
  logic [DATA_W-1:0]        lo_tap [CAPACITY];
  logic [DATA_W-1:0]        hi_tap [CAPACITY];
  logic [DATA_W-1:0]        lo_sel;
  logic [DATA_W-1:0]        hi_sel;

  logic signed [DATA_W:0]   sum;
  logic signed [DATA_W:0]   adj;

  assign in_stall  = state_r != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign drop      = cnt_r >= Cap;
  assign ins.en    = accept && !drop;
  assign ins.sample = in_data.sample;

  assign n_nxt      = drop ? cnt_r : cnt_r + 1'b1;
  assign hi_idx_nxt = n_nxt >> 1;
  assign lo_idx_nxt = n_nxt[0] ? hi_idx_nxt : hi_idx_nxt - 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_data.last_item ? '0 : n_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lgt;
    logic signed [DATA_W-1:0] lval;
    if (i == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lval = '0;
    end else begin : g_body
      assign lgt  = gt[i-1];
      assign lval = val[i-1];
    end
    rmt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ins      (ins),
      .fill     (cnt_r),
      .left_gt  (lgt),
      .left_val (lval),
      .lo_idx   (lo_idx_r),
      .hi_idx   (hi_idx_r),
      .gt       (gt[i]),
      .val      (val[i]),
      .lo_tap   (lo_tap[i]),
      .hi_tap   (hi_tap[i])
    );
  end

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lo_sel = lo_sel | lo_tap[i];
      hi_sel = hi_sel | hi_tap[i];
    end
  end

  // sum one bit wider, round toward zero before halving
  assign sum = {lo_r[DATA_W-1], lo_r} + {hi_r[DATA_W-1], hi_r};
  assign adj = sum + {{DATA_W{1'b0}}, sum[DATA_W] & sum[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (out_valid_r && !out_stall && state_r != ST_SUM) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            n_r      <= n_nxt;
            hi_idx_r <= hi_idx_nxt;
            lo_idx_r <= lo_idx_nxt;
            drop_r   <= drop;
            state_r  <= ST_SEL;
          end
        end
        ST_SEL: begin
          lo_r    <= lo_sel;
          hi_r    <= hi_sel;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (!out_valid_r || !out_stall) begin
            out_r.median     <= adj[DATA_W:1];
            out_r.held_count <= HELD_W'(n_r);
            out_r.dropped    <= drop_r;
            out_valid_r      <= 1'b1;
            state_r          <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: test/running_median_tracker_tb.sv
// running_median_tracker_tb: checks the running median block against an in-bench predictor
// directed corner cases, store overflow, random runs, bursty idling on both sides or none
// depends on rmt_pkg and running_median_tracker
module running_median_tracker_tb;
  import rmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  running_median_tracker #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predictor state
  logic signed [DATA_W-1:0] sorted_samples [CAPACITY];
  int held_n = 0;
  out_t pending_medians [$];

  bit idle_en = 1'b0;
  bit idle_allowed = 1'b1;
  int sent_n = 0;
  int checked_n = 0;
  int runs_n = 0;
  int drops_seen = 0;
  int errors = 0;
  int cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic out_t predict_median(in_t item);
    out_t res;
    int pos;
    longint lo;
    longint hi;
    res = '0;
    res.dropped = (held_n >= CAPACITY);
    if (!res.dropped) begin
      pos = held_n;
      while (pos > 0 && sorted_samples[pos-1] > item.sample) begin
        sorted_samples[pos] = sorted_samples[pos-1];
        pos = pos - 1;
      end
      sorted_samples[pos] = item.sample;
      held_n = held_n + 1;
    end
    if (held_n % 2 == 1) begin
      res.median = sorted_samples[held_n/2];
    end else begin
      lo = sorted_samples[held_n/2-1];
      hi = sorted_samples[held_n/2];
      res.median = DATA_W'((lo + hi) / 2);
    end
    res.held_count = HELD_W'(held_n);
    if (item.last_item) held_n = 0;
    return res;
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic push_sample(logic signed [DATA_W-1:0] s, bit last);
    in_t item;
    item.sample    = s;
    item.last_item = last;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_medians.insert(pending_medians.size(), predict_median(item));
    sent_n = sent_n + 1;
    if (last) runs_n = runs_n + 1;
  endtask

  // result side: bursty stall
  initial begin
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_n = checked_n + 1;
      if (out_data.dropped) drops_seen = drops_seen + 1;
      if (pending_medians.size() == 0) begin
        errors = errors + 1;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: median %0d held %0d dropped %0b",
                   out_data.median, out_data.held_count, out_data.dropped);
      end else begin
        want = pending_medians.pop_front();
        if (out_data.median !== want.median || out_data.held_count !== want.held_count ||
            out_data.dropped !== want.dropped) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS)
            $display("mismatch on result %0d: exp %0d/%0d/%0b got %0d/%0d/%0b", checked_n,
                     want.median, want.held_count, want.dropped,
                     out_data.median, out_data.held_count, out_data.dropped);
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_sample();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = $signed($urandom_range(0, 20)) - 10;
      end
      1: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = 32'h7ffffffe;
          3: v = 32'h80000001;
          4: v = 32'hffffffff;
          default: v = '0;
        endcase
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic test_extremes();
    push_sample(32'h7fffffff, 1'b0);
    push_sample(32'h7fffffff, 1'b1);
    push_sample(32'h80000000, 1'b0);
    push_sample(32'h80000000, 1'b1);
    // even-count sums with odd totals that truncate toward zero
    push_sample(32'h7fffffff, 1'b0);
    push_sample(32'h80000000, 1'b1);
    push_sample(-32'sd1, 1'b0);
    push_sample(-32'sd2, 1'b1);
    push_sample(32'sd1, 1'b0);
    push_sample(32'sd2, 1'b1);
    push_sample(32'h5a5a5a5a, 1'b1);
    push_sample(32'ha5a5a5a5, 1'b1);
  endtask

  task automatic test_equal_values();
    push_sample(32'sd7, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(32'sd3, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(32'sd3, 1'b0);
    push_sample(32'sd3, 1'b1);
  endtask

  // fill past capacity and end the run on a dropped sample
  task automatic test_store_full();
    for (int i = 0; i < CAPACITY + 2; i++)
      push_sample(pick_sample(), i == CAPACITY + 1);
    push_sample(32'sd42, 1'b1);
  endtask

  task automatic test_random_runs(int n_items);
    int run_len;
    int stop_at;
    stop_at = sent_n + n_items;
    while (sent_n < stop_at) begin
      idle_en = idle_allowed && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0)
        run_len = $urandom_range(CAPACITY - 4, CAPACITY + 8);
      else
        run_len = $urandom_range(1, 24);
      for (int i = 0; i < run_len; i++)
        push_sample(pick_sample(), i == run_len - 1);
    end
  endtask

  task automatic test_no_idle(int n_items);
    idle_allowed = 1'b0;
    idle_en = 1'b0;
    test_random_runs(n_items);
    idle_en = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;
    test_extremes();
    test_equal_values();
    test_store_full();
    test_random_runs(1200);
    test_no_idle(300);
    in_valid <= 1'b0;
    idle_en = 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d samples in %0d runs, checked %0d medians, %0d with a dropped sample",
             sent_n, runs_n, checked_n, drops_seen);
    if (errors == 0 && pending_medians.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
